>>> rtl/irle_pkg.sv
// Shared types and constants for the image run-length encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package irle_pkg;

	localparam int PIXEL_W   = 16;
	localparam int POS_W     = 12;
	localparam int LEN_W     = 24;
	localparam int DIM_W     = 13;
	localparam int CFG_IDX_W = 2;

	// output queue: two slots of headroom per accepted pixel
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_COUNT      = 2'd0,
		CFG_COLUMN_COUNT   = 2'd1,
		CFG_SKIP_ZERO_MODE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [DIM_W-1:0] row_count;
		logic [DIM_W-1:0] column_count;
		logic             skip_zero_mode;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]   start_row;
		logic [POS_W-1:0]   start_column;
		logic [PIXEL_W-1:0] run_value;
		logic [LEN_W-1:0]   run_length;
		logic               last_run;
	} run_t;

	// up to two runs closed by one pixel, oldest in slot r0
	typedef struct packed {
		logic [1:0] n;
		run_t       r0;
		run_t       r1;
	} push_t;

endpackage

`default_nettype wire

>>> rtl/irle_if.sv
// Valid/ready channel interfaces: pixels in, runs out, register writes.
// Depends on irle_pkg.
`default_nettype none

interface pixel_if import irle_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface run_if import irle_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   start_row;
	logic [POS_W-1:0]   start_column;
	logic [PIXEL_W-1:0] run_value;
	logic [LEN_W-1:0]   run_length;
	logic               last_run;
	modport source (output valid, output start_row, output start_column, output run_value,
		output run_length, output last_run, input ready);
	modport sink   (input valid, input start_row, input start_column, input run_value,
		input run_length, input last_run, output ready);
endinterface

interface cfg_if import irle_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/irle_cfg_regs.sv
// Configuration register file: row count, column count, zero-skip mode.
// Depends on irle_pkg.
`default_nettype none

module irle_cfg_regs import irle_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_valid,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [DIM_W-1:0]     wr_data,
	output logic                      wr_ready,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	assign wr_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count      <= DIM_W'(1);
			cfg_q.column_count   <= DIM_W'(1);
			cfg_q.skip_zero_mode <= 1'b0;
		end else if (wr_valid) begin
			unique case (cfg_reg_t'(wr_index))
				CFG_ROW_COUNT:      cfg_q.row_count      <= wr_data;
				CFG_COLUMN_COUNT:   cfg_q.column_count   <= wr_data;
				CFG_SKIP_ZERO_MODE: cfg_q.skip_zero_mode <= wr_data[0];
				default:            ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/irle_core.sv
// Run tracker: raster position, open run and the runs each pixel closes.
// Depends on irle_pkg.
`default_nettype none

module irle_core import irle_pkg::*; #(
	parameter int MAX_DIMENSION = 4096,
	parameter int PIXEL_BITS    = 16,
	parameter int LENGTH_BITS   = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [PIXEL_W-1:0] pixel,
	input  wire cfg_t               cfg,
	output push_t                   push
);

	localparam int PW   = $clog2(MAX_DIMENSION);
	localparam int CMPW = (PW + 1 > DIM_W) ? PW + 1 : DIM_W;
	localparam logic [PIXEL_W-1:0] PIX_MASK = (PIXEL_BITS >= PIXEL_W) ? {PIXEL_W{1'b1}} :
		PIXEL_W'((33'd1 << PIXEL_BITS) - 33'd1);

	logic [PW-1:0]          cur_row_q, cur_col_q, cur_row_n, cur_col_n;
	logic [PIXEL_W-1:0]     open_value_q, open_value_n;
	logic [PW-1:0]          open_row_q, open_col_q, open_row_n, open_col_n;
	logic [LENGTH_BITS-1:0] open_len_q, open_len_n;
	logic                   run_open_q, run_ended_q, run_open_n, run_ended_n;

	logic [PIXEL_W-1:0] px;
	logic [CMPW-1:0]    rows, cols;
	logic               skip, end_row, end_img, emit_a, emit_b;
	run_t               res_a, res_b;

	function automatic logic [CMPW-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [CMPW-1:0] w;
		w = CMPW'(v);
		if (v == '0)
			return CMPW'(1);
		else if (w > CMPW'(MAX_DIMENSION))
			return CMPW'(MAX_DIMENSION);
		else
			return w;
	endfunction

	function automatic run_t make_run(input logic [PW-1:0] r, input logic [PW-1:0] c,
		input logic [PIXEL_W-1:0] v, input logic [LENGTH_BITS-1:0] l, input logic last);
		run_t o;
		o.start_row    = POS_W'(r);
		o.start_column = POS_W'(c);
		o.run_value    = v;
		o.run_length   = LEN_W'(l);
		o.last_run     = last;
		return o;
	endfunction

	always_comb begin
		px   = pixel & PIX_MASK;
		skip = cfg.skip_zero_mode;
		rows = clamp_dim(cfg.row_count);
		cols = clamp_dim(cfg.column_count);

		open_value_n = open_value_q;
		open_row_n   = open_row_q;
		open_col_n   = open_col_q;
		open_len_n   = open_len_q;
		run_open_n   = run_open_q;
		run_ended_n  = run_ended_q;
		emit_a       = 1'b0;

		priority if (skip && px == '0) begin
			// a zero ends the held run; it is reported later
			if (run_open_q)
				run_ended_n = 1'b1;
		end else if (run_open_q && !run_ended_q && px == open_value_q) begin
			if (open_len_q != '1)
				open_len_n = open_len_q + 1'b1;
		end else begin
			emit_a       = run_open_q;
			open_value_n = px;
			open_row_n   = cur_row_q;
			open_col_n   = cur_col_q;
			open_len_n   = LENGTH_BITS'(1);
			run_open_n   = 1'b1;
			run_ended_n  = 1'b0;
		end

		end_row = (CMPW'(cur_col_q) + CMPW'(1)) >= cols;
		end_img = end_row && ((CMPW'(cur_row_q) + CMPW'(1)) >= rows);
		emit_b  = end_row && (!skip || end_img) && run_open_n;

		res_a = make_run(open_row_q, open_col_q, open_value_q, open_len_q, 1'b0);
		res_b = make_run(open_row_n, open_col_n, open_value_n, open_len_n, end_img);

		if (emit_b) begin
			run_open_n  = 1'b0;
			run_ended_n = 1'b0;
		end

		priority if (end_img) begin
			cur_row_n = '0;
			cur_col_n = '0;
		end else if (end_row) begin
			cur_row_n = cur_row_q + 1'b1;
			cur_col_n = '0;
		end else begin
			cur_row_n = cur_row_q;
			cur_col_n = cur_col_q + 1'b1;
		end

		push.n  = accept ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
		push.r0 = emit_a ? res_a : res_b;
		push.r1 = res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			open_value_q <= '0;
			open_row_q   <= '0;
			open_col_q   <= '0;
			open_len_q   <= '0;
			run_open_q   <= 1'b0;
			run_ended_q  <= 1'b0;
		end else if (accept) begin
			cur_row_q    <= cur_row_n;
			cur_col_q    <= cur_col_n;
			open_value_q <= open_value_n;
			open_row_q   <= open_row_n;
			open_col_q   <= open_col_n;
			open_len_q   <= open_len_n;
			run_open_q   <= run_open_n;
			run_ended_q  <= run_ended_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/irle_queue.sv
// Shifting output queue; slot 0 drives the run channel directly.
// Depends on irle_pkg.
`default_nettype none

module irle_queue import irle_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       space,
	output run_t       head,
	output logic       valid,
	input  wire logic  pop_ready
);

	run_t              ent_q [QUEUE_DEPTH];
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	logic [QIDX_W-1:0] base;

	assign valid = count_q != '0;
	assign head  = ent_q[0];
	assign pop   = valid && pop_ready;
	// a pixel may close two runs, so two free slots are needed to take it
	assign space = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign base  = QIDX_W'(count_q - QCNT_W'(pop));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_q - QCNT_W'(pop) + QCNT_W'(push.n);
	end

	// each slot takes a new run, or its neighbor's run on a pop, or holds
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (push.n != 2'd0 && QIDX_W'(i) == base)
				ent_q[i] <= push.r0;
			else if (push.n == 2'd2 && QIDX_W'(i) == base + QIDX_W'(1))
				ent_q[i] <= push.r1;
			else if (pop && i < QUEUE_DEPTH - 1)
				ent_q[i] <= ent_q[QIDX_W'(i + 1)];
		end
	end

endmodule

`default_nettype wire

>>> rtl/image_run_length_encoder_unit.sv
// Image run-length encoder top level: config regs, run tracker, output queue.
// Depends on irle_pkg, irle_if, irle_cfg_regs, irle_core, irle_queue.
//
// Usage:
//  - pixels: one pixel per transfer in raster order. The position counter
//    wraps to row 0, column 0 after the last pixel of an image.
//  - runs: start row, start column, value, length (saturating) and a flag
//    on the run that closes the image. Mode 0 closes every run at its row
//    end; mode 1 skips zero pixels and lets runs continue across rows.
//  - cfg: register writes (0 row count, 1 column count, 2 zero-skip mode),
//    always ready; write only while no pixel is in flight.
// Timing:
//  - A run is written into the registered output queue by the pixel transfer
//    that closes it and reaches the runs channel once the runs ahead are taken.
//  - One pixel per cycle while runs are taken. The run channel moves one
//    run per cycle, so a pixel closing two runs (value change at a row or
//    image end) puts two runs in the queue at once; the 4-entry output queue
//    absorbs this and pixels keep flowing as long as two slots are free.
//  - Receiver stall: the queue fills and pixels.ready drops once fewer than
//    two slots are free; nothing is lost and the head run stays stable.
//  - Reset (arst_n low): position, open run and queue cleared, registers
//    back to 1 row, 1 column, mode 0. No clearing pass is needed.
`default_nettype none

module image_run_length_encoder_unit import irle_pkg::*; #(
	parameter int MAX_DIMENSION = 4096,
	parameter int PIXEL_BITS    = 16,
	parameter int LENGTH_BITS   = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	pixel_if.sink    pixels,
	run_if.source    runs,
	cfg_if.sink      cfg
);

	cfg_t  cfg_cur;
	push_t push;
	run_t  head;
	logic  space;
	logic  accept;

	// a pixel transfer completes whenever two queue slots are free
	assign pixels.ready = space;
	assign accept       = pixels.valid && space;

	irle_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.wr_ready (cfg.ready),
		.cfg      (cfg_cur)
	);

	irle_core #(
		.MAX_DIMENSION (MAX_DIMENSION),
		.PIXEL_BITS    (PIXEL_BITS),
		.LENGTH_BITS   (LENGTH_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.pixel  (pixels.pixel),
		.cfg    (cfg_cur),
		.push   (push)
	);

	irle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.head      (head),
		.valid     (runs.valid),
		.pop_ready (runs.ready)
	);

	// queue head is registered; drive the run channel straight from it
	assign runs.start_row    = head.start_row;
	assign runs.start_column = head.start_column;
	assign runs.run_value    = head.run_value;
	assign runs.run_length   = head.run_length;
	assign runs.last_run     = head.last_run;

endmodule

`default_nettype wire

>>> rtl/irle_checker.sv
// Port-level checks for the image run-length encoder, bound to the top level.
// Depends on irle_pkg and image_run_length_encoder_unit.
`default_nettype none

module irle_checker import irle_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [POS_W-1:0]   out_row,
	input wire logic [POS_W-1:0]   out_col,
	input wire logic [PIXEL_W-1:0] out_value,
	input wire logic [LEN_W-1:0]   out_length,
	input wire logic               out_last
);

	// stalled run holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({out_row, out_col, out_value,
			out_length, out_last}))
		else $error("run changed while stalled");

	// pixel back-pressure only comes from runs waiting downstream
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("pixel input stalled with no run pending");

	// a run shows up only after a pixel transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("run appeared without a pixel transfer");

	// every reported run covers at least one pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_length != '0)
		else $error("run of zero length");

endmodule

bind image_run_length_encoder_unit irle_checker u_irle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pixels.valid),
	.in_ready   (pixels.ready),
	.out_valid  (runs.valid),
	.out_ready  (runs.ready),
	.out_row    (runs.start_row),
	.out_col    (runs.start_column),
	.out_value  (runs.run_value),
	.out_length (runs.run_length),
	.out_last   (runs.last_run)
);

`default_nettype wire
